[rtl/core/mtep_pkg.sv]
// ----------------------------------------------------------------------------
// mtep_pkg: shared types and constants of the MIDI track event parser
// Phase codes, event kinds and the record passed from front to back.
// ----------------------------------------------------------------------------
package mtep_pkg;

   typedef enum logic [8:0] {
      PH_DELTA  = 9'b000000001,
      PH_STATUS = 9'b000000010,
      PH_DATA1  = 9'b000000100,
      PH_DATA2  = 9'b000001000,
      PH_MTYPE  = 9'b000010000,
      PH_MLEN   = 9'b000100000,
      PH_MSKIP  = 9'b001000000,
      PH_TEMPO  = 9'b010000000,
      PH_SYSEX  = 9'b100000000
   } phase_type;

   localparam logic [3:0] KIND_TRUNC = 4'd0;
   localparam logic [3:0] KIND_NON   = 4'd1;
   localparam logic [3:0] KIND_NOFF  = 4'd2;
   localparam logic [3:0] KIND_TEMPO = 4'd3;
   localparam logic [3:0] KIND_EOT   = 4'd4;
   localparam logic [3:0] KIND_CHAN  = 4'd5;
   localparam logic [3:0] KIND_META  = 4'd6;
   localparam logic [3:0] KIND_SYSEX = 4'd7;
   localparam logic [3:0] KIND_SYS   = 4'd8;

   // voice operation carried to the back end
   typedef enum logic [1:0] {
      VOICE_NONE = 2'd0,
      VOICE_UP   = 2'd1,
      VOICE_DOWN = 2'd2
   } voice_op_type;

   localparam int QueueDepth = 2;

   // one classified event from the front end
   typedef struct packed {
      logic [3:0]   kind;
      logic [3:0]   channel;
      logic [7:0]   first_data;
      logic [7:0]   second_data;
      logic [63:0]  tick;
      logic [23:0]  tempo;
      logic [31:0]  notes;
      voice_op_type voice_op;
      logic         done;
   } event_type;

endpackage

[rtl/core/mtep_front.sv]
// ----------------------------------------------------------------------------
// mtep_front: byte parser
// Walks the track grammar one byte per beat and emits classified events.
// ----------------------------------------------------------------------------
module mtep_front import mtep_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [7:0]  in_byte,
   input  logic        in_first,
   input  logic        in_last,
   output logic        ev_valid,
   input  logic        ev_ready,
   output event_type   ev_data
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  rs_ff, rs_in;
   logic [63:0] tick_ff, tick_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  mtype_ff, mtype_in;
   logic [31:0] skip_ff, skip_in;
   logic [7:0]  held_ff, held_in;
   logic [23:0] tempo_ff, tempo_in;
   logic [31:0] notes_ff, notes_in;
   logic        over_ff, over_in;

   logic        emit;
   event_type   ev;
   logic        take;

   assign in_ready = ev_ready;
   assign take     = in_valid & in_ready;

   // classify a status byte (fresh or running)
   function automatic phase_type status_next(input logic [7:0] c);
      if (c < 8'hF0 || c == 8'hF2 || c == 8'hF3) return PH_DATA1;
      else if (c == 8'hFF) return PH_MTYPE;
      else if (c == 8'hF0) return PH_SYSEX;
      else return PH_DELTA;
   endfunction

   always_comb begin
      phase_type   ph;
      logic [7:0]  rs, mt, held, b, c, hi;
      logic [63:0] tk;
      logic [31:0] acc, skip, notes, len;
      logic [23:0] tmp;
      logic        ov, redo;
      b = in_byte;
      if (in_first) begin
         ph = PH_DELTA; rs = '0; tk = '0; acc = '0; mt = '0; skip = '0;
         held = '0; tmp = '0; notes = '0; ov = 1'b0;
      end else begin
         ph = phase_ff; rs = rs_ff; tk = tick_ff; acc = acc_ff; mt = mtype_ff;
         skip = skip_ff; held = held_ff; tmp = tempo_ff; notes = notes_ff;
         ov = over_ff;
      end
      emit = 1'b0;
      ev = '0;
      // events carry the tick before a reparsed byte adds its delta
      ev.tick = tk;
      redo = 1'b0;
      c = 8'h00; hi = 8'h00; len = '0;
      if (!ov) begin
         // a running-status or orphan byte in status position is reparsed
         if (ph == PH_STATUS) begin
            if (b >= 8'h80 || rs != 8'h00) begin
               c = (b >= 8'h80) ? b : rs;
               rs = c;
               ph = status_next(c);
               if (ph == PH_DELTA) begin
                  emit = 1'b1;
                  ev.kind = KIND_SYS;
                  ev.channel = c[3:0];
               end
               redo = (b < 8'h80);
            end else begin
               ph = PH_DELTA;
               redo = 1'b1;
            end
         end
         if (phase_ff != PH_STATUS || in_first || redo) begin
            hi = rs & 8'hF0;
            case (ph)
               PH_DELTA: begin
                  acc = {acc[24:0], b[6:0]};
                  if (!b[7]) begin
                     tk = tk + {32'd0, acc};
                     acc = '0;
                     ph = PH_STATUS;
                  end
               end
               PH_STATUS: begin
                  // not reached: status position is handled above
                  if (b >= 8'h80 || rs != 8'h00) begin
                     c = (b >= 8'h80) ? b : rs;
                     rs = c;
                     ph = status_next(c);
                     if (ph == PH_DELTA) begin
                        emit = 1'b1; ev.kind = KIND_SYS; ev.channel = c[3:0];
                     end
                  end else begin
                     ph = PH_DELTA;
                  end
               end
               PH_DATA1, PH_DATA2: begin
                  if (ph == PH_DATA1) held = b;
                  if (ph == PH_DATA1 && !(hi == 8'hC0 || hi == 8'hD0 || rs == 8'hF3))
                  begin
                     ph = PH_DATA2;
                  end else begin
                     emit = 1'b1;
                     ev.channel = rs[3:0];
                     ev.first_data = (ph == PH_DATA1) ? b : held;
                     ev.second_data = (ph == PH_DATA1) ? 8'h00 : b;
                     ph = PH_DELTA;
                     if (hi == 8'h90) begin
                        ev.kind = KIND_NON;
                        if (ev.second_data != 8'h00) begin
                           if (notes != '1) notes = notes + 32'd1;
                           ev.voice_op = VOICE_UP;
                        end else begin
                           ev.voice_op = VOICE_DOWN;
                        end
                     end else if (hi == 8'h80) begin
                        ev.kind = KIND_NOFF; ev.voice_op = VOICE_DOWN;
                     end else if (hi == 8'hF0) begin
                        ev.kind = KIND_SYS;
                     end else begin
                        ev.kind = KIND_CHAN;
                     end
                  end
               end
               PH_MTYPE: begin
                  mt = b; acc = '0; ph = PH_MLEN;
               end
               PH_MLEN: begin
                  acc = {acc[24:0], b[6:0]};
                  if (!b[7]) begin
                     len = acc;
                     acc = '0;
                     case (mt)
                        8'h00: skip = 32'd2;
                        8'h20, 8'h21: skip = 32'd1;
                        8'h54: skip = 32'd5;
                        8'h58: skip = 32'd4;
                        8'h59: skip = 32'd2;
                        8'h51: skip = 32'd3;
                        default: skip = len;
                     endcase
                     if (mt == 8'h2F) begin
                        skip = skip_ff;
                        if (in_first) skip = '0;
                        emit = 1'b1; ev.kind = KIND_EOT; ev.channel = 4'hF;
                        ev.first_data = 8'h2F; ov = 1'b1; ph = PH_DELTA;
                     end else if (mt == 8'h51) begin
                        tmp = '0; ph = PH_TEMPO;
                     end else if (skip == '0) begin
                        emit = 1'b1; ev.kind = KIND_META; ev.channel = rs[3:0];
                        ev.first_data = mt; ph = PH_DELTA;
                     end else begin
                        ph = PH_MSKIP;
                     end
                  end
               end
               PH_MSKIP: begin
                  skip = skip - 32'd1;
                  if (skip == '0) begin
                     emit = 1'b1; ev.kind = KIND_META; ev.channel = rs[3:0];
                     ev.first_data = mt; ph = PH_DELTA;
                  end
               end
               PH_TEMPO: begin
                  tmp = {tmp[15:0], b};
                  skip = skip - 32'd1;
                  if (skip == '0) begin
                     emit = 1'b1; ev.kind = KIND_TEMPO; ev.channel = rs[3:0];
                     ev.first_data = mt; ev.tempo = tmp; ph = PH_DELTA;
                  end
               end
               PH_SYSEX: begin
                  if (b == 8'hF7) begin
                     emit = 1'b1; ev.kind = KIND_SYSEX; ev.channel = rs[3:0];
                     ph = PH_DELTA;
                  end
               end
               default: ph = PH_DELTA;
            endcase
         end
         if (in_last && !ov) begin
            if (!emit) begin
               emit = 1'b1;
               ev = '0;
               ev.kind = KIND_TRUNC;
               ev.tick = tk;
            end
            ov = 1'b1;
         end
      end
      ev.notes = notes;
      ev.done  = ov;
      phase_in = ph; rs_in = rs; tick_in = tk; acc_in = acc; mtype_in = mt;
      skip_in = skip; held_in = held; tempo_in = tmp; notes_in = notes;
      over_in = ov;
   end

   assign ev_valid = take & emit;
   assign ev_data  = ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DELTA;
         rs_ff    <= '0;
         tick_ff  <= '0;
         acc_ff   <= '0;
         mtype_ff <= '0;
         skip_ff  <= '0;
         held_ff  <= '0;
         tempo_ff <= '0;
         notes_ff <= '0;
         over_ff  <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in;
         rs_ff    <= rs_in;
         tick_ff  <= tick_in;
         acc_ff   <= acc_in;
         mtype_ff <= mtype_in;
         skip_ff  <= skip_in;
         held_ff  <= held_in;
         tempo_ff <= tempo_in;
         notes_ff <= notes_in;
         over_ff  <= over_in;
      end
   end

endmodule

[rtl/core/mtep_queue.sv]
// ----------------------------------------------------------------------------
// mtep_queue: event queue
// Two-entry register queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module mtep_queue import mtep_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_valid,
   output logic      wr_ready,
   input  event_type wr_data,
   output logic      rd_valid,
   input  logic      rd_ready,
   output event_type rd_data
);

   event_type  slot_ff [QueueDepth];
   logic [1:0] count_ff, count_in;
   logic       head_ff, head_in, tail_ff, tail_in;
   logic       push, pop;

   assign wr_ready = (count_ff != 2'(QueueDepth));
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = slot_ff[head_ff];
   assign push     = wr_valid & wr_ready;
   assign pop      = rd_valid & rd_ready;

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      head_in  = head_ff ^ pop;
      tail_in  = tail_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[tail_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

endmodule

[rtl/core/mtep_back.sv]
// ----------------------------------------------------------------------------
// mtep_back: voice tracker and output register
// Applies voice updates in event order and holds the outgoing beat.
// ----------------------------------------------------------------------------
module mtep_back import mtep_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        ev_valid,
   output logic        ev_ready,
   input  event_type   ev_data,
   output logic        out_valid,
   input  logic        out_ready,
   output event_type   out_data,
   output logic [31:0] out_voices
);

   logic [31:0] voice_ff, voice_in;
   logic        valid_ff, valid_in;
   event_type   data_ff;
   logic        load;

   assign ev_ready = !valid_ff || out_ready;
   assign load     = ev_valid & ev_ready;

   always_comb begin
      voice_in = voice_ff;
      case (ev_data.voice_op)
         VOICE_UP:   if (voice_ff != '1) voice_in = voice_ff + 32'd1;
         VOICE_DOWN: if (voice_ff != '0) voice_in = voice_ff - 32'd1;
         default:    voice_in = voice_ff;
      endcase
      valid_in = load | (valid_ff & !out_ready);
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= ev_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (load) voice_ff <= voice_in;
      end
   end

   // the counter holds the value after the event in the output register
   assign out_valid  = valid_ff;
   assign out_data   = data_ff;
   assign out_voices = voice_ff;

endmodule

[rtl/core/midi_track_event_parser.sv]
// ----------------------------------------------------------------------------
// midi_track_event_parser: MIDI track chunk event parser
// Parses track bytes into events with tick time, tempo and note counts.
// ----------------------------------------------------------------------------
//  channel   | ports             | direction | beat
//  ----------+-------------------+-----------+-------------------------------
//  request   | req_valid/ready   | in        | one track byte plus flags
//  response  | rsp_valid/ready   | out       | one completed event
//
// One byte a cycle while the queue has room; an event is registered in the
// queue on its last byte and then in the output register. The parser
// advances with the queue: req_ready drops only while the two-entry queue
// is full. Reset clears all parser state and the polyphony counter.
// ----------------------------------------------------------------------------
module midi_track_event_parser import mtep_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_of_track,
   input  logic        req_last_of_chunk,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_event_kind,
   output logic [3:0]  rsp_channel,
   output logic [7:0]  rsp_first_data,
   output logic [7:0]  rsp_second_data,
   output logic [63:0] rsp_tick_position,
   output logic [23:0] rsp_tempo_value,
   output logic [31:0] rsp_note_total,
   output logic [31:0] rsp_polyphony,
   output logic        rsp_track_done
);

   logic      f_valid, f_ready, q_valid, q_ready;
   event_type f_data, q_data, o_data;

   // front: grammar walk, one byte per beat
   mtep_front u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_byte(req_data_byte),
      .in_first(req_first_of_track), .in_last(req_last_of_chunk),
      .ev_valid(f_valid), .ev_ready(f_ready), .ev_data(f_data)
   );

   // decouple the parser from output stalls
   mtep_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
   );

   // back: polyphony and the output register
   mtep_back u_back (
      .clock, .reset,
      .ev_valid(q_valid), .ev_ready(q_ready), .ev_data(q_data),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(o_data),
      .out_voices(rsp_polyphony)
   );

   assign rsp_event_kind    = o_data.kind;
   assign rsp_channel       = o_data.channel;
   assign rsp_first_data    = o_data.first_data;
   assign rsp_second_data   = o_data.second_data;
   assign rsp_tick_position = o_data.tick;
   assign rsp_tempo_value   = o_data.tempo;
   assign rsp_note_total    = o_data.notes;
   assign rsp_track_done    = o_data.done;

endmodule

[rtl/core/mtep_checker.sv]
// ----------------------------------------------------------------------------
// mtep_checker: port checks
// Watches the top level ports for protocol and result consistency.
// ----------------------------------------------------------------------------
module mtep_checker import mtep_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_event_kind,
   input logic [7:0]  rsp_first_data,
   input logic [23:0] rsp_tempo_value,
   input logic        rsp_track_done
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind))
      else $error("rsp beat dropped while stalled");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_kind <= KIND_SYS)
      else $error("bad event kind");

   a_eot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == KIND_EOT || rsp_event_kind == KIND_TRUNC)
      |-> rsp_track_done)
      else $error("track end without done");

   a_tempo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != KIND_TEMPO |-> rsp_tempo_value == '0)
      else $error("tempo on non-tempo event");

   a_eotdata: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == KIND_EOT |-> rsp_first_data == 8'h2F)
      else $error("end of track type wrong");

endmodule

bind midi_track_event_parser mtep_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_event_kind, .rsp_first_data,
   .rsp_tempo_value, .rsp_track_done
);

[test/midi_track_event_parser_test.sv]
// ----------------------------------------------------------------------------
// midi_track_event_parser_test: self-checking bench for the track parser
// Feeds track byte streams through a bursty driver, predicts each event in
// a local parser model and checks every response beat field by field.
// ----------------------------------------------------------------------------
module midi_track_event_parser_test;
   import mtep_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       first;
      logic       last;
   } byte_beat_type;

   typedef struct {
      logic [3:0]  kind;
      logic [3:0]  chan;
      logic [7:0]  d1;
      logic [7:0]  d2;
      logic [63:0] tick;
      logic [23:0] tempo;
      logic [31:0] notes;
      logic [31:0] voices;
      logic        done;
   } midi_event_type;

   // parser phases of the predictor
   typedef enum logic [8:0] {
      P_DELTA  = 9'b000000001,
      P_STATUS = 9'b000000010,
      P_DATA1  = 9'b000000100,
      P_DATA2  = 9'b000001000,
      P_MTYPE  = 9'b000010000,
      P_MLEN   = 9'b000100000,
      P_MSKIP  = 9'b001000000,
      P_TEMPO  = 9'b010000000,
      P_SYSEX  = 9'b100000000
   } parse_step_type;

   localparam int IdleLimit = 20000;
   localparam int DrainCycles = 12;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_first_of_track = 1'b0;
   logic        req_last_of_chunk = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_event_kind;
   logic [3:0]  rsp_channel;
   logic [7:0]  rsp_first_data;
   logic [7:0]  rsp_second_data;
   logic [63:0] rsp_tick_position;
   logic [23:0] rsp_tempo_value;
   logic [31:0] rsp_note_total;
   logic [31:0] rsp_polyphony;
   logic        rsp_track_done;

   midi_track_event_parser dut (.*);

   always #2 clock = ~clock;

   byte_beat_type  pending_bytes[$];
   midi_event_type expected_events[$];
   int  error_count = 0;
   int  bytes_sent = 0;
   int  events_seen = 0;
   int  tracks_built = 0;
   bit  stimulus_done = 1'b0;
   bit  hold_sender = 1'b0;
   bit  long_stall = 1'b0;
   int  idle_cycles = 0;
   bit  req_ready_seen = 1'b0;

   // predictor state
   parse_step_type pstep;
   logic [7:0]  run_status;
   logic [63:0] ticks;
   logic [31:0] vlq;
   logic [7:0]  mtype;
   logic [31:0] skip_left;
   logic [7:0]  held;
   logic [23:0] tempo_acc;
   logic [31:0] notes;
   logic [31:0] voices;
   bit          over;
   bit          have_event;
   bit          retake;
   midi_event_type pend_event;

   function automatic void clear_track_state();
      pstep = P_DELTA;
      run_status = '0;
      ticks = '0;
      vlq = '0;
      mtype = '0;
      skip_left = '0;
      held = '0;
      tempo_acc = '0;
      notes = '0;
      over = 1'b0;
   endfunction

   function automatic void post_event(logic [3:0] kind, logic [3:0] chan, logic [7:0] d1,
                                      logic [7:0] d2, logic [23:0] tempo);
      pend_event = '{kind, chan, d1, d2, ticks, tempo, notes, voices, 1'b0};
      have_event = 1'b1;
   endfunction

   function automatic void close_channel_event(logic [7:0] d1, logic [7:0] d2);
      logic [3:0] kind;
      pstep = P_DELTA;
      case (run_status[7:4])
         4'h9: begin
            if (d2 != 0) begin
               if (notes != '1) notes++;
               if (voices != '1) voices++;
            end else if (voices != 0) voices--;
            kind = KIND_NON;
         end
         4'h8: begin
            if (voices != 0) voices--;
            kind = KIND_NOFF;
         end
         4'hF: kind = KIND_SYS;
         default: kind = KIND_CHAN;
      endcase
      post_event(kind, run_status[3:0], d1, d2, '0);
   endfunction

   function automatic void close_meta_length(logic [31:0] len);
      logic [31:0] n;
      case (mtype)
         8'h2F: begin
            post_event(KIND_EOT, 4'hF, 8'h2F, '0, '0);
            over = 1'b1;
            pstep = P_DELTA;
            return;
         end
         8'h51: begin
            skip_left = 3;
            tempo_acc = '0;
            pstep = P_TEMPO;
            return;
         end
         8'h00, 8'h59: n = 2;
         8'h20, 8'h21: n = 1;
         8'h54: n = 5;
         8'h58: n = 4;
         default: n = len;
      endcase
      skip_left = n;
      if (n == 0) begin
         post_event(KIND_META, run_status[3:0], mtype, '0, '0);
         pstep = P_DELTA;
      end else pstep = P_MSKIP;
   endfunction

   function automatic void parse_byte(logic [7:0] b);
      logic [7:0] cmd;
      case (pstep)
         P_DELTA: begin
            vlq = {vlq[24:0], b[6:0]};
            if (!b[7]) begin
               ticks += vlq;
               vlq = '0;
               pstep = P_STATUS;
            end
         end
         P_STATUS: begin
            if (!b[7] && run_status == 0) begin
               pstep = P_DELTA;
               retake = 1'b1;
               return;
            end
            cmd = b[7] ? b : run_status;
            run_status = cmd;
            if (cmd < 8'hF0 || cmd == 8'hF2 || cmd == 8'hF3) pstep = P_DATA1;
            else if (cmd == 8'hFF) pstep = P_MTYPE;
            else if (cmd == 8'hF0) pstep = P_SYSEX;
            else begin
               post_event(KIND_SYS, cmd[3:0], '0, '0, '0);
               pstep = P_DELTA;
            end
            if (!b[7]) retake = 1'b1;
         end
         P_DATA1: begin
            held = b;
            if (run_status[7:4] == 4'hC || run_status[7:4] == 4'hD || run_status == 8'hF3)
               close_channel_event(b, '0);
            else pstep = P_DATA2;
         end
         P_DATA2: close_channel_event(held, b);
         P_MTYPE: begin
            mtype = b;
            vlq = '0;
            pstep = P_MLEN;
         end
         P_MLEN: begin
            vlq = {vlq[24:0], b[6:0]};
            if (!b[7]) begin
               logic [31:0] len;
               len = vlq;
               vlq = '0;
               close_meta_length(len);
            end
         end
         P_MSKIP: begin
            skip_left--;
            if (skip_left == 0) begin
               post_event(KIND_META, run_status[3:0], mtype, '0, '0);
               pstep = P_DELTA;
            end
         end
         P_TEMPO: begin
            tempo_acc = {tempo_acc[15:0], b};
            skip_left--;
            if (skip_left == 0) begin
               post_event(KIND_TEMPO, run_status[3:0], mtype, '0, tempo_acc);
               pstep = P_DELTA;
            end
         end
         default: begin
            if (b == 8'hF7) begin
               post_event(KIND_SYSEX, run_status[3:0], '0, '0, '0);
               pstep = P_DELTA;
            end
         end
      endcase
   endfunction

   // Advance the predictor by one accepted beat and queue any event it yields.
   function automatic void predict_event(byte_beat_type bt);
      if (bt.first) clear_track_state();
      if (over) return;
      have_event = 1'b0;
      for (int pass = 0; pass < 2; pass++) begin
         retake = 1'b0;
         parse_byte(bt.data);
         if (!retake || over) break;
      end
      if (bt.last && !over) begin
         if (!have_event) post_event(KIND_TRUNC, '0, '0, '0, '0);
         over = 1'b1;
      end
      if (have_event) begin
         pend_event.done = over;
         expected_events.insert(expected_events.size(), pend_event);
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at event %0d: %s got %0h expected %0h", events_seen, what, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------- stimulus
   function automatic void push_byte(logic [7:0] b, bit first = 1'b0, bit last = 1'b0);
      byte_beat_type bt;
      bt.data = b;
      bt.first = first;
      bt.last = last;
      pending_bytes.insert(pending_bytes.size(), bt);
   endfunction

   function automatic void push_vlq(logic [31:0] v);
      int n;
      n = (v >= 32'h1000_0000) ? 5 : (v >= 32'h20_0000) ? 4 : (v >= 32'h4000) ? 3 :
          (v >= 32'h80) ? 2 : 1;
      for (int i = n - 1; i >= 0; i--)
         push_byte({i != 0, 7'((v >> (7 * i)) & 32'h7F)});
   endfunction

   function automatic logic [31:0] rand_delta();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1, 2: return $urandom_range(0, 20000);
         default: return $urandom_range(0, 127);
      endcase
   endfunction

   // One random event body after its delta time; running status sometimes.
   function automatic void push_event_body(bit allow_running);
      logic [7:0] st;
      logic [7:0] mt;
      int len;
      case ($urandom_range(0, 11))
         0, 1, 2, 3: begin
            st = {4'h9, 4'($urandom)};
            if (!(allow_running && $urandom_range(0, 2) == 0)) push_byte(st);
            push_byte(8'($urandom_range(0, 127)));
            push_byte($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom));
         end
         4, 5: begin
            push_byte({4'h8, 4'($urandom)});
            push_byte(8'($urandom));
            push_byte(8'($urandom));
         end
         6: begin
            push_byte({3'($urandom_range(5, 6)), 1'b0, 4'($urandom)} | 8'h80);
            push_byte(8'($urandom));
            if ($urandom_range(0, 1)) push_byte(8'($urandom));
         end
         7: begin
            push_byte(8'hFF);
            push_byte(8'h51);
            push_byte(8'h03);
            repeat (3) push_byte(8'($urandom));
         end
         8: begin
            mt = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 127)) :
                 8'h00 + 8'($urandom_range(0, 1)) * 8'h20;
            if (mt == 8'h2F || mt == 8'h51) mt = 8'h01;
            push_byte(8'hFF);
            push_byte(mt);
            len = $urandom_range(0, 6);
            push_vlq(len);
            case (mt)
               8'h00, 8'h59: len = 2;
               8'h20, 8'h21: len = 1;
               8'h54: len = 5;
               8'h58: len = 4;
               default: ;
            endcase
            repeat (len) push_byte(8'($urandom));
         end
         9: begin
            push_byte(8'hF0);
            repeat ($urandom_range(0, 5)) push_byte(8'($urandom_range(0, 127)));
            push_byte(8'hF7);
         end
         10: begin
            st = 8'($urandom_range(8'hF1, 8'hFE));
            if (st == 8'hF7) st = 8'hF2;
            push_byte(st);
            if (st == 8'hF2 || st == 8'hF3) push_byte(8'($urandom));
            if (st == 8'hF2) push_byte(8'($urandom));
         end
         default: push_byte(8'($urandom));
      endcase
   endfunction

   // A track: mostly well formed, sometimes cut short or full of noise.
   function automatic void push_track();
      int n_events;
      int mode;
      int start;
      mode = $urandom_range(0, 9);
      n_events = $urandom_range(1, 12);
      start = pending_bytes.size();
      for (int i = 0; i < n_events; i++) begin
         if (mode == 0) push_byte(8'($urandom));
         else begin
            push_vlq(rand_delta());
            push_event_body(i != 0);
         end
      end
      if (mode > 2) begin
         push_byte(8'h00);
         push_byte(8'hFF);
         push_byte(8'h2F);
         push_byte(8'h00);
      end
      pending_bytes[start].first = 1'b1;
      if (mode != 1) pending_bytes[pending_bytes.size() - 1].last = 1'b1;
      tracks_built++;
   endfunction

   function automatic void push_directed();
      // running status before any status byte, then a zero-velocity note-on
      push_byte(8'h05, 1'b1);
      push_byte(8'h7F);
      push_byte(8'h00);
      push_byte(8'h90); push_byte(8'h3C); push_byte(8'h64);
      push_byte(8'h00); push_byte(8'h3C); push_byte(8'h00);
      push_byte(8'h00); push_byte(8'h80); push_byte(8'hFF); push_byte(8'h80);
      // long delta time keeps the low 32 bits
      push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF);
      push_byte(8'hFF); push_byte(8'h7F);
      push_byte(8'hFF); push_byte(8'h51); push_byte(8'h03);
      push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF, 1'b0, 1'b1);
      // running status on a body-less system status, then the last byte of the chunk
      push_byte(8'h00, 1'b1); push_byte(8'hF6); push_byte(8'h00);
      push_byte(8'h00, 1'b0, 1'b1);
   endfunction

   // ------------------------------------------------------------------ driver
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready_seen) begin
         if (hold_sender || pending_bytes.size() == 0) begin
            req_valid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_data_byte <= pending_bytes[0].data;
            req_first_of_track <= pending_bytes[0].first;
            req_last_of_chunk <= pending_bytes[0].last;
            void'(pending_bytes.pop_front());
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            end
         end
      end
   end

   // receiver stall pattern and long hold-off
   int stall_phase = 0;

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (long_stall) rsp_ready <= 1'b0;
      else begin
         stall_phase = (stall_phase + 1) % 64;
         rsp_ready <= (stall_phase < 24) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   // ----------------------------------------------------------------- monitor
   always @(posedge clock) begin
      req_ready_seen = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            byte_beat_type bt;
            bt.data = req_data_byte;
            bt.first = req_first_of_track;
            bt.last = req_last_of_chunk;
            predict_event(bt);
            bytes_sent++;
            req_ready_seen = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               report_mismatch("unexpected event", 64'(rsp_event_kind), '0);
            end else begin
               midi_event_type w;
               w = expected_events.pop_front();
               if (rsp_event_kind !== w.kind)
                  report_mismatch("kind", 64'(rsp_event_kind), 64'(w.kind));
               if (rsp_channel !== w.chan)
                  report_mismatch("channel", 64'(rsp_channel), 64'(w.chan));
               if (rsp_first_data !== w.d1)
                  report_mismatch("first_data", 64'(rsp_first_data), 64'(w.d1));
               if (rsp_second_data !== w.d2)
                  report_mismatch("second_data", 64'(rsp_second_data), 64'(w.d2));
               if (rsp_tick_position !== w.tick)
                  report_mismatch("tick_position", rsp_tick_position, w.tick);
               if (rsp_tempo_value !== w.tempo)
                  report_mismatch("tempo_value", 64'(rsp_tempo_value), 64'(w.tempo));
               if (rsp_note_total !== w.notes)
                  report_mismatch("note_total", 64'(rsp_note_total), 64'(w.notes));
               if (rsp_polyphony !== w.voices)
                  report_mismatch("polyphony", 64'(rsp_polyphony), 64'(w.voices));
               if (rsp_track_done !== w.done)
                  report_mismatch("track_done", 64'(rsp_track_done), 64'(w.done));
            end
            events_seen++;
         end
         // watchdog: count cycles with no beat on either channel
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else if (!stimulus_done || expected_events.size() != 0) idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("watchdog expired, %0d events outstanding", expected_events.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------- flow
   initial begin
      clear_track_state();
      voices = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      push_directed();
      while (pending_bytes.size() < 350) push_track();
      // hold the receiver off while the sender keeps offering beats
      @(posedge clock);
      long_stall = 1'b1;
      for (int c = 0; c < 300; c++) @(posedge clock);
      long_stall = 1'b0;
      wait (pending_bytes.size() == 0);
      // pause the sender until every expected event has drained
      hold_sender = 1'b1;
      wait (expected_events.size() == 0 && !req_valid);
      hold_sender = 1'b0;
      while (pending_bytes.size() < 350) push_track();
      wait (pending_bytes.size() == 0);
      @(posedge clock);
      while (req_valid) @(posedge clock);
      stimulus_done = 1'b1;
      wait (expected_events.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      $display("covered %0d bytes in %0d tracks, %0d events checked", bytes_sent,
               tracks_built, events_seen);
      if (error_count == 0 && expected_events.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
